// ----- rtl/core/cofd_pkg.sv -----
// shared constants, types and sequencer states for the clock offset filter
// no dependencies
package cofd_pkg;

  localparam int SAMPLE_DEPTH = 16;
  localparam int PTR_W        = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W        = 5;
  localparam int TS_W         = 32;
  localparam int DLY_W        = 31;
  localparam int ALU_W        = TS_W + 1;

  localparam logic [DLY_W-1:0] DELAY_MAX       = {DLY_W{1'b1}};
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RST = CNT_W'(4);
  localparam logic [CNT_W-1:0] DEPTH_CNT       = CNT_W'(SAMPLE_DEPTH);
  localparam logic             ACT_RECORD      = 1'b0;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [DLY_W-1:0] dly_t;
  typedef logic [ALU_W-1:0] alu_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_D0   = 11'b000_0000_0010,
    S_D1   = 11'b000_0000_0100,
    S_SUM  = 11'b000_0000_1000,
    S_HALF = 11'b000_0001_0000,
    S_D2   = 11'b000_0010_0000,
    S_D3   = 11'b000_0100_0000,
    S_DLY  = 11'b000_1000_0000,
    S_SCAN = 11'b001_0000_0000,
    S_XLAT = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic we;
    ptr_t waddr;
    ptr_t raddr;
  } store_ctl_t;

endpackage

// ----- rtl/core/cofd_if.sv -----
// valid/ready channel interfaces for exchange words and result words
// depends on cofd_pkg
interface cofd_in_if;
  import cofd_pkg::*;
  logic valid;
  logic ready;
  logic action;
  ts_t  send_time;
  ts_t  server_receive_time;
  ts_t  server_send_time;
  ts_t  local_receive_time;
  ts_t  server_time;

  modport source (
    output valid, action, send_time, server_receive_time, server_send_time,
           local_receive_time, server_time,
    input  ready
  );
  modport sink (
    input  valid, action, send_time, server_receive_time, server_send_time,
           local_receive_time, server_time,
    output ready
  );
endinterface

interface cofd_out_if;
  import cofd_pkg::*;
  logic valid;
  logic ready;
  logic valid_res;
  ts_t  best_offset;
  dly_t best_delay;
  dly_t jitter;
  ts_t  translated_time;
  cnt_t stored_count;

  modport source (
    output valid, valid_res, best_offset, best_delay, jitter, translated_time,
           stored_count,
    input  ready
  );
  modport sink (
    input  valid, valid_res, best_offset, best_delay, jitter, translated_time,
           stored_count,
    output ready
  );
endinterface

// ----- rtl/core/cofd_alu.sv -----
// shared 33-bit add/subtract unit for the sample and translation arithmetic
// depends on cofd_pkg
module cofd_alu (
  input  cofd_pkg::alu_t a,
  input  cofd_pkg::alu_t b,
  input  logic           sub,
  output cofd_pkg::alu_t y
);
  import cofd_pkg::*;

  alu_t b_eff;

  assign b_eff = sub ? ~b : b;
  assign y     = a + b_eff + alu_t'(sub);

endmodule

// ----- rtl/core/cofd_store.sv -----
// sample ring memory: offset and delay per entry, one write and one read port
// read data registered; depends on cofd_pkg
module cofd_store (
  input  logic                  clk,
  input  cofd_pkg::store_ctl_t  ctl,
  input  cofd_pkg::ts_t         wr_offset,
  input  cofd_pkg::dly_t        wr_delay,
  output cofd_pkg::ts_t         rd_offset,
  output cofd_pkg::dly_t        rd_delay
);
  import cofd_pkg::*;

  ts_t  offset_mem [SAMPLE_DEPTH];
  dly_t delay_mem  [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      offset_mem[ctl.waddr] <= wr_offset;
      delay_mem[ctl.waddr]  <= wr_delay;
    end
    rd_offset <= offset_mem[ctl.raddr];
    rd_delay  <= delay_mem[ctl.raddr];
  end

endmodule

// ----- rtl/core/clock_offset_min_delay_filter.sv -----
// Clock offset filter: each input word either records a timestamp exchange
// (four microsecond stamps) into a sixteen-entry sample ring or only asks for
// a report; every word yields one result word with the offset of the
// lowest-delay stored sample, the largest stored delay and the server time
// translated by that offset (valid_res low, the offset and time zero and the
// delay DELAY_MAX while fewer than min_samples samples are stored). One shared
// 33-bit adder does all arithmetic under a small sequencer: a word goes through
// the sample arithmetic (record only), then a scan of the ring memory through
// its registered read port, then translation and presentation of the result,
// and back to idle to accept the next word; a finished result waits while the
// previous result word is still not taken. in_ch.ready is high only while the
// sequencer is idle. The user must set min_samples through cfg_we/cfg_data
// only while idle; the block itself does not enforce it.
// depends on cofd_pkg, cofd_if, cofd_alu, cofd_store
module clock_offset_min_delay_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cofd_pkg::cnt_t       cfg_data,
  cofd_in_if.sink              in_ch,
  cofd_out_if.source           out_ch
);
  import cofd_pkg::*;

  state_t     state_r, state_nxt;
  cnt_t       min_samples_r;
  ptr_t       wp_r;
  cnt_t       fill_r;
  cnt_t       idx_r;
  logic       pend_r;
  logic       found_r;
  logic       out_valid_r;

  ts_t        t0_r, t1_r, t2_r, t3_r, srv_r;
  alu_t       acc0_r, acc1_r;
  ts_t        off_r;
  ts_t        best_off_r;
  dly_t       best_dly_r;
  dly_t       jit_r;

  logic       res_valid_r;
  ts_t        res_off_r;
  dly_t       res_dly_r;
  dly_t       res_jit_r;
  ts_t        res_xlat_r;
  cnt_t       res_cnt_r;

  alu_t       alu_a, alu_b, alu_y;
  logic       alu_sub;
  store_ctl_t st_ctl;
  ts_t        rd_offset;
  dly_t       rd_delay;
  dly_t       dly_clamp;
  logic       sample_valid;

  cofd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  cofd_store u_store (
    .clk       (clk),
    .ctl       (st_ctl),
    .wr_offset (off_r),
    .wr_delay  (dly_clamp),
    .rd_offset (rd_offset),
    .rd_delay  (rd_delay)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  // operand selection for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_D0: begin
        alu_a = {1'b0, t1_r};
        alu_b = {1'b0, t0_r};
      end
      S_D1: begin
        alu_a = {1'b0, t2_r};
        alu_b = {1'b0, t3_r};
      end
      S_SUM: begin
        alu_a   = {acc0_r[TS_W-1], acc0_r[TS_W-1:0]};
        alu_b   = {acc1_r[TS_W-1], acc1_r[TS_W-1:0]};
        alu_sub = 1'b0;
      end
      S_HALF: begin
        // arithmetic halve, round toward zero
        alu_a   = {acc0_r[ALU_W-1], acc0_r[ALU_W-1:1]};
        alu_b   = alu_t'(acc0_r[ALU_W-1] & acc0_r[0]);
        alu_sub = 1'b0;
      end
      S_D2: begin
        alu_a = {1'b0, t3_r};
        alu_b = {1'b0, t0_r};
      end
      S_D3: begin
        alu_a = {1'b0, t2_r};
        alu_b = {1'b0, t1_r};
      end
      S_DLY: begin
        alu_a = {acc0_r[TS_W-1], acc0_r[TS_W-1:0]};
        alu_b = {acc1_r[TS_W-1], acc1_r[TS_W-1:0]};
      end
      S_XLAT: begin
        alu_a = {1'b0, srv_r};
        alu_b = {1'b0, best_off_r};
      end
      S_IDLE, S_SCAN, S_OUT: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // clamp delay at zero and saturate to 31 bits
  always_comb begin
    if (alu_y[ALU_W-1]) begin
      dly_clamp = '0;
    end else if (alu_y[TS_W-1]) begin
      dly_clamp = DELAY_MAX;
    end else begin
      dly_clamp = alu_y[DLY_W-1:0];
    end
  end

  assign st_ctl.we    = (state_r == S_DLY);
  assign st_ctl.waddr = wp_r;
  assign st_ctl.raddr = idx_r[PTR_W-1:0];
  assign sample_valid = (fill_r >= min_samples_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.action == ACT_RECORD) ? S_D0 : S_SCAN;
        end
      end
      S_D0:   state_nxt = S_D1;
      S_D1:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_HALF;
      S_HALF: state_nxt = S_D2;
      S_D2:   state_nxt = S_D3;
      S_D3:   state_nxt = S_DLY;
      S_DLY:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (idx_r >= fill_r && !pend_r) begin
          state_nxt = S_XLAT;
        end
      end
      S_XLAT: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      min_samples_r <= MIN_SAMPLES_RST;
      wp_r          <= '0;
      fill_r        <= '0;
      idx_r         <= '0;
      pend_r        <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        min_samples_r <= cfg_data;
      end
      if (state_r == S_IDLE) begin
        idx_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (state_r == S_DLY) begin
        wp_r <= (wp_r == ptr_t'(SAMPLE_DEPTH - 1)) ? '0 : wp_r + ptr_t'(1);
        if (fill_r < DEPTH_CNT) begin
          fill_r <= fill_r + cnt_t'(1);
        end
      end
      if (state_r == S_SCAN) begin
        if (idx_r < fill_r) begin
          idx_r  <= idx_r + cnt_t'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r) begin
          found_r <= 1'b1;
        end
      end
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      t0_r     <= in_ch.send_time;
      t1_r     <= in_ch.server_receive_time;
      t2_r     <= in_ch.server_send_time;
      t3_r     <= in_ch.local_receive_time;
      srv_r    <= in_ch.server_time;
    end
    if (state_r == S_IDLE) begin
      best_off_r <= '0;
      best_dly_r <= DELAY_MAX;
      jit_r      <= '0;
    end
    unique case (state_r)
      S_D0, S_SUM, S_D2: acc0_r <= alu_y;
      S_D1, S_D3:        acc1_r <= alu_y;
      S_HALF:            off_r  <= alu_y[TS_W-1:0];
      S_SCAN: begin
        if (pend_r) begin
          if (!found_r || rd_delay < best_dly_r) begin
            best_dly_r <= rd_delay;
            best_off_r <= rd_offset;
          end
          if (rd_delay > jit_r) begin
            jit_r <= rd_delay;
          end
        end
      end
      S_XLAT: begin
        res_valid_r <= sample_valid;
        res_off_r   <= sample_valid ? best_off_r : '0;
        res_dly_r   <= sample_valid ? best_dly_r : DELAY_MAX;
        res_jit_r   <= jit_r;
        res_xlat_r  <= sample_valid ? alu_y[TS_W-1:0] : '0;
        res_cnt_r   <= fill_r;
      end
      S_IDLE, S_DLY, S_OUT: begin
        acc1_r <= acc1_r;
      end
      default: begin
        acc1_r <= acc1_r;
      end
    endcase
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_ch.valid_res       <= res_valid_r;
      out_ch.best_offset     <= res_off_r;
      out_ch.best_delay      <= res_dly_r;
      out_ch.jitter          <= res_jit_r;
      out_ch.translated_time <= res_xlat_r;
      out_ch.stored_count    <= res_cnt_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// ----- dv/clock_offset_min_delay_filter_test.sv -----
// self-checking bench for clock_offset_min_delay_filter: directed table, then random phases
// drives the exchange channel, checks each result word against a local filter model or a fixed table entry
// depends on cofd_pkg, cofd_if and the rtl top level
module clock_offset_min_delay_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cofd_pkg::*;

  localparam logic ACT_REPORT = 1'b1;
  localparam int   DIR_ROWS   = 17;
  localparam int   PHASES     = 8;
  localparam int   PHASE_LEN  = 175;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic action;
    ts_t  send_time;
    ts_t  server_receive_time;
    ts_t  server_send_time;
    ts_t  local_receive_time;
    ts_t  server_time;
  } exchange_t;

  typedef struct packed {
    logic valid_res;
    ts_t  best_offset;
    dly_t best_delay;
    dly_t jitter;
    ts_t  translated_time;
    cnt_t stored_count;
  } report_t;

  typedef struct packed {
    row_kind_t kind;
    cnt_t      cfg;
    exchange_t w;
    report_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cnt_t cfg_data = '0;

  cofd_in_if  in_ch ();
  cofd_out_if out_ch ();

  clock_offset_min_delay_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  // local copy of the sample ring and the threshold
  ts_t  offset_mem [SAMPLE_DEPTH];
  dly_t delay_mem [SAMPLE_DEPTH];
  int   slot_ptr = 0;
  int   ring_fill = 0;
  cnt_t need_samples = MIN_SAMPLES_RST;

  report_t pending_reports [$];
  int      mismatch_count = 0;
  bit      no_idle = 1'b0;
  bit      drv_fixed = 1'b0;
  report_t drv_fixed_want = '0;

  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FIXED, 5'd0, '{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h12345678},
      '{1'b0, 32'h0, DELAY_MAX, 31'h0, 32'h0, 5'd0}},
    '{ROW_CFG, 5'd0, '0, '0},
    '{ROW_FIXED, 5'd0, '{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF},
      '{1'b1, 32'h0, DELAY_MAX, 31'h0, 32'hFFFFFFFF, 5'd0}},
    '{ROW_FIXED, 5'd0, '{ACT_RECORD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5},
      '{1'b1, 32'h0, 31'h0, 31'h0, 32'h5, 5'd1}},
    '{ROW_PREDICT, 5'd0,
      '{ACT_RECORD, 32'h0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h0}, '0},
    '{ROW_PREDICT, 5'd0,
      '{ACT_RECORD, 32'h80000000, 32'h0, 32'h0, 32'h80000000, 32'h1}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'd10, 32'd7, 32'd20, 32'd20, 32'h2}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'd0, 32'd4, 32'd5, 32'd6, 32'h3}, '0},
    '{ROW_PREDICT, 5'd0,
      '{ACT_RECORD, 32'h0, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h4}, '0},
    '{ROW_CFG, 5'd16, '0, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'hFFFFFFFF}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'd100, 32'd150, 32'd160, 32'd120, 32'h7}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'd200, 32'd300, 32'd310, 32'd220, 32'h8}, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_RECORD, 32'hAAAAAAAA, 32'h55555555, 32'h55555560,
      32'hAAAAAAB0, 32'h55555555}, '0},
    '{ROW_CFG, 5'd31, '0, '0},
    '{ROW_PREDICT, 5'd0, '{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0, 32'hDEADBEEF}, '0}
  };

  function automatic report_t compute_report(input exchange_t w);
    report_t r;
    ts_t     fwd, back, round, hold, lo_off;
    longint  sum, dly;
    dly_t    lo, hi;
    if (w.action == ACT_RECORD) begin
      fwd   = w.server_receive_time - w.send_time;
      back  = w.server_send_time - w.local_receive_time;
      round = w.local_receive_time - w.send_time;
      hold  = w.server_send_time - w.server_receive_time;
      sum   = longint'($signed(fwd)) + longint'($signed(back));
      dly   = longint'($signed(round)) - longint'($signed(hold));
      if (dly < 0) dly = 0;
      if (dly > longint'(DELAY_MAX)) dly = longint'(DELAY_MAX);
      offset_mem[slot_ptr] = ts_t'(sum / 2);
      delay_mem[slot_ptr]  = dly_t'(dly);
      slot_ptr = (slot_ptr + 1) % SAMPLE_DEPTH;
      if (ring_fill < SAMPLE_DEPTH) ring_fill++;
    end
    lo = DELAY_MAX;
    hi = '0;
    lo_off = '0;
    // earliest index wins a tie
    for (int i = 0; i < ring_fill; i++) begin
      if (i == 0 || delay_mem[i] < lo) begin
        lo = delay_mem[i];
        lo_off = offset_mem[i];
      end
      if (delay_mem[i] > hi) hi = delay_mem[i];
    end
    r.valid_res       = (ring_fill >= need_samples);
    r.best_offset     = r.valid_res ? lo_off : '0;
    r.best_delay      = r.valid_res ? lo : DELAY_MAX;
    r.jitter          = hi;
    r.translated_time = r.valid_res ? w.server_time - lo_off : '0;
    r.stored_count    = cnt_t'(ring_fill);
    return r;
  endfunction

  function automatic exchange_t random_exchange();
    exchange_t   w;
    int unsigned pick;
    ts_t         skew;
    pick = $urandom_range(99);
    w.action = (pick < 15) ? ACT_REPORT : ACT_RECORD;
    w.server_time = $urandom;
    w.send_time = $urandom;
    if (pick >= 85) begin
      w.server_receive_time = $urandom;
      w.server_send_time = $urandom;
      w.local_receive_time = $urandom;
    end else begin
      skew = ($urandom_range(3) == 0) ? ts_t'($urandom) : ts_t'($urandom_range(2000) - 1000);
      // small one-way delays make ties common
      w.server_receive_time = w.send_time + skew +
        (($urandom_range(3) == 0) ? $urandom_range(50000) : $urandom_range(3));
      w.server_send_time = w.server_receive_time + $urandom_range(500);
      w.local_receive_time = w.server_send_time - skew +
        (($urandom_range(3) == 0) ? $urandom_range(50000) : $urandom_range(3));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("mismatch in %s at %0t: got %0h, want %0h", what, $time, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input exchange_t w, input bit fixed, input report_t want);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid               = 1'b1;
    in_ch.action              = w.action;
    in_ch.send_time           = w.send_time;
    in_ch.server_receive_time = w.server_receive_time;
    in_ch.server_send_time    = w.server_send_time;
    in_ch.local_receive_time  = w.local_receive_time;
    in_ch.server_time         = w.server_time;
    drv_fixed                 = fixed;
    drv_fixed_want            = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_min_samples(input cnt_t v);
    drain();
    cfg_we = 1'b1;
    cfg_data = v;
    need_samples = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    exchange_t taken;
    report_t   seen, want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken = '{in_ch.action, in_ch.send_time, in_ch.server_receive_time,
                in_ch.server_send_time, in_ch.local_receive_time, in_ch.server_time};
      want = compute_report(taken);
      pending_reports.push_back(drv_fixed ? drv_fixed_want : want);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.valid_res, out_ch.best_offset, out_ch.best_delay, out_ch.jitter,
               out_ch.translated_time, out_ch.stored_count};
      if (pending_reports.size() == 0) begin
        report_mismatch("word with nothing expected", 64'(seen.translated_time), 64'h0);
      end else begin
        want = pending_reports.pop_front();
        if (seen.valid_res !== want.valid_res)
          report_mismatch("valid_res", 64'(seen.valid_res), 64'(want.valid_res));
        if (seen.best_offset !== want.best_offset)
          report_mismatch("best_offset", 64'(seen.best_offset), 64'(want.best_offset));
        if (seen.best_delay !== want.best_delay)
          report_mismatch("best_delay", 64'(seen.best_delay), 64'(want.best_delay));
        if (seen.jitter !== want.jitter)
          report_mismatch("jitter", 64'(seen.jitter), 64'(want.jitter));
        if (seen.translated_time !== want.translated_time)
          report_mismatch("translated_time", 64'(seen.translated_time),
                          64'(want.translated_time));
        if (seen.stored_count !== want.stored_count)
          report_mismatch("stored_count", 64'(seen.stored_count), 64'(want.stored_count));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = no_idle || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    cnt_t phase_cfg [PHASES];
    in_ch.valid = 1'b0;
    in_ch.action = ACT_RECORD;
    in_ch.send_time = '0;
    in_ch.server_receive_time = '0;
    in_ch.server_send_time = '0;
    in_ch.local_receive_time = '0;
    in_ch.server_time = '0;
    phase_cfg = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd17, 5'd31, 5'd8, cnt_t'($urandom_range(16))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_min_samples(dir_rows[i].cfg);
      else
        send_word(dir_rows[i].w, dir_rows[i].kind == ROW_FIXED, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_min_samples(phase_cfg[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // let the pipeline empty out once mid-phase
        if (ph == 4 && n == PHASE_LEN / 2) drain();
        send_word(random_exchange(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
